>>> sv/tpsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_pkg
// Shared types, constants and helpers of the two-phase square wave generator.
// ----------------------------------------------------------------------------
package tpsw_pkg;

  localparam int SET_W   = 7;
  localparam int PER_W   = 16;
  localparam int PH_W    = 9;
  localparam int WIN_W   = 17;
  localparam int DIV_N_W = 25;
  localparam int DIV_D_W = 9;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 32;

  localparam logic [CFG_A_W-1:0] REG_BASE_HZ    = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_TPS        = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_PHASE_STEP = 2'd2;

  localparam logic [6:0]        BASE_HZ_RST    = 7'd11;
  localparam logic [15:0]       TPS_RST        = 16'd2000;
  localparam logic [5:0]        PHASE_STEP_RST = 6'd36;
  localparam logic [SET_W-1:0]  SETTING_RST    = 7'd11;
  localparam logic [SET_W-1:0]  SETTING_MAX    = 7'd99;
  localparam logic [SET_W-1:0]  TENS_STEP      = 7'd10;
  localparam logic [DIV_D_W-1:0] DEG_FULL      = 9'd360;
  localparam logic [PH_W-1:0]   DEG_HALF       = 9'd180;
  localparam logic [PH_W-1:0]   PHASE_SAT      = 9'd511;
  // ceil(2^32 / 360), exact quotient for products below 2^25
  localparam logic [RECIP_W-1:0] RECIP_360     = 24'd11930465;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_TENS_UP  = 3'd1,
    OP_TENS_DN  = 3'd2,
    OP_UNITS_UP = 3'd3,
    OP_UNITS_DN = 3'd4,
    OP_LOAD     = 3'd5
  } opcode_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic p_start;
    logic ld_period;
    logic ld_prod;
    logic ld_quot;
    logic ld_win;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic op_derive;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  // tens digit of a setting up to 99 by reciprocal multiply
  function automatic logic [3:0] tens_of(input logic [SET_W-1:0] s);
    logic [14:0] p;
    p = 15'(s) * 15'd205;
    return p[14:11];
  endfunction

endpackage

>>> sv/tpsw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpsw_div #(
  parameter int N_W = 16,
  parameter int D_W = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [N_W-1:0] quotient
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   den_r, den_nxt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  assign trial = {rem_r, quo_r[N_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(N_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_nxt = {quo_r[N_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider not busy after start");
`endif

endmodule

>>> sv/tpsw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_dp
// Datapath: registers, setting update, period and phase window derivation,
// wave levels and the output register.
// ----------------------------------------------------------------------------
module tpsw_dp
  import tpsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [15:0]        in_tdata,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata
);

  localparam int OUT_W = 2 + SET_W + PER_W;
  localparam int RP_W  = DIV_N_W + RECIP_W;

  logic [6:0]       base_hz_r;
  logic [15:0]      tps_r;
  logic [5:0]       step_r;
  logic [SET_W-1:0] setting_r, setting_nxt;
  logic [PER_W-1:0] cnt_r, cnt_nxt;
  logic [PER_W-1:0] period_r;
  logic [PH_W-1:0]  phase_r;
  logic [DIV_N_W-1:0] prod_r;
  logic [WIN_W-1:0] quot_r;
  logic [WIN_W-1:0] lo_r, hi_r;
  opcode_t          op_r;
  logic [SET_W-1:0] ns_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic [3:0]       tens;
  logic [3:0]       units;
  logic [SET_W-1:0] tens_x10;
  logic [7:0]       freq;
  logic [DIV_D_W-1:0] freq_div;
  logic [9:0]       ph_raw;
  logic [PH_W-1:0]  phase_nxt;
  logic [PH_W-1:0]  ph_eff;
  logic [DIV_N_W-1:0] prod;
  logic [RP_W-1:0]  recip_prod;
  logic [DIV_N_W-1:0] back;
  logic [PER_W:0]   cnt_inc;
  logic [PER_W-1:0] div_q;
  logic             div_busy, div_done;
  logic             wave_a, wave_b, in_win;

  assign tens      = tens_of(setting_r);
  assign tens_x10  = SET_W'(tens) * TENS_STEP;
  assign units     = 4'(setting_r - tens_x10);
  assign freq      = 8'(base_hz_r) + 8'(tens);
  assign freq_div  = (freq == 8'd0) ? DIV_D_W'(1) : DIV_D_W'(freq);
  assign ph_raw    = 10'(step_r) * 10'(units);
  assign phase_nxt = (ph_raw > 10'(PHASE_SAT)) ? PHASE_SAT : ph_raw[PH_W-1:0];
  assign ph_eff    = (phase_r > DEG_HALF) ? (phase_r - DEG_HALF) : phase_r;
  assign prod      = DIV_N_W'(period_r) * DIV_N_W'(ph_eff);
  assign recip_prod = RP_W'(prod_r) * RP_W'(RECIP_360);
  assign back      = DIV_N_W'(quot_r) * DIV_N_W'(DEG_FULL);
  assign cnt_inc   = {1'b0, cnt_r} + (PER_W+1)'(1);

  tpsw_div #(
    .N_W (PER_W),
    .D_W (DIV_D_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.p_start),
    .dividend (tps_r),
    .divisor  (freq_div),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    setting_nxt = setting_r;
    cnt_nxt     = cnt_r;
    unique case (op_r)
      OP_TICK: begin
        cnt_nxt = (cnt_inc > {1'b0, period_r}) ? '0 : cnt_inc[PER_W-1:0];
      end
      OP_TENS_UP: begin
        if (setting_r <= SETTING_MAX - TENS_STEP) setting_nxt = setting_r + TENS_STEP;
      end
      OP_TENS_DN: begin
        if (setting_r >= TENS_STEP) setting_nxt = setting_r - TENS_STEP;
      end
      OP_UNITS_UP: begin
        if (setting_r < SETTING_MAX) setting_nxt = setting_r + SET_W'(1);
      end
      OP_UNITS_DN: begin
        if (setting_r != '0) setting_nxt = setting_r - SET_W'(1);
      end
      OP_LOAD: begin
        setting_nxt = (ns_r > SETTING_MAX) ? SETTING_MAX : ns_r;
      end
      default: begin
        setting_nxt = setting_r;
      end
    endcase
  end

  assign wave_a = cnt_r <= (period_r >> 1);
  assign in_win = ({1'b0, cnt_r} >= lo_r) && ({1'b0, cnt_r} <= hi_r);
  assign wave_b = in_win ^ (phase_r > DEG_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_hz_r   <= BASE_HZ_RST;
      tps_r       <= TPS_RST;
      step_r      <= PHASE_STEP_RST;
      setting_r   <= SETTING_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_BASE_HZ:    base_hz_r <= cfg_wdata[6:0];
          REG_TPS:        tps_r     <= cfg_wdata[15:0];
          REG_PHASE_STEP: step_r    <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (cmd.apply) begin
        setting_r <= setting_nxt;
        cnt_r     <= cnt_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.capture) begin
      op_r <= opcode_t'(in_tdata[2:0]);
      ns_r <= in_tdata[9:3];
    end
    if (cmd.p_start) phase_r <= phase_nxt;
    if (cmd.ld_period) period_r <= div_q;
    if (cmd.ld_prod) prod_r <= prod;
    // floor of product / 360 by reciprocal multiply
    if (cmd.ld_quot) quot_r <= recip_prod[RECIP_SH +: WIN_W];
    if (cmd.ld_win) begin
      lo_r <= quot_r + WIN_W'(back != prod_r);
      hi_r <= WIN_W'(period_r >> 1) + quot_r;
    end
    if (cmd.emit) out_data_r <= {period_r, setting_r, wave_b, wave_a};
  end

  always_comb begin
    sts.op_derive = (op_r != OP_TICK) && (op_r <= OP_LOAD);
    sts.div_busy  = div_busy;
    sts.div_done  = div_done;
    sts.out_free  = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 32'(out_data_r);

`ifndef NO_ASSERTIONS
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result not presented after emit");
`endif

endmodule

>>> sv/tpsw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsw_ctrl
// Controller: sequences item handling and the period / phase derivation.
// ----------------------------------------------------------------------------
module tpsw_ctrl
  import tpsw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    cfg_we,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_P_START,
    S_P_WAIT,
    S_MUL,
    S_QUOT,
    S_WIN,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   pending_r, pending_nxt;
  logic   item_r, item_nxt;
  logic   in_fire;

  assign in_tready = (state_r == S_IDLE) && !pending_r;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    pending_nxt = pending_r;
    item_nxt    = item_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (pending_r) begin
          pending_nxt = 1'b0;
          item_nxt    = 1'b0;
          state_nxt   = S_P_START;
        end else if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        item_nxt  = 1'b1;
        state_nxt = sts.op_derive ? S_P_START : S_RESULT;
      end
      S_P_START: begin
        cmd.p_start = 1'b1;
        state_nxt   = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (sts.div_done) begin
          cmd.ld_period = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.ld_prod = 1'b1;
        state_nxt   = S_QUOT;
      end
      S_QUOT: begin
        cmd.ld_quot = 1'b1;
        state_nxt   = S_WIN;
      end
      S_WIN: begin
        cmd.ld_win = 1'b1;
        state_nxt  = item_r ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) pending_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pending_r <= 1'b1;
      item_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pending_r <= pending_nxt;
      item_r    <= item_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second transfer taken while an item is in work");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result overwrites an untaken transfer");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.p_start |-> !sts.div_busy)
    else $error("divider started while busy");
`endif

endmodule

>>> sv/two_phase_square_wave_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_square_wave_generator_top
// Two 50% duty square waves, the second phase shifted, from a 0..99 setting.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item returns one transfer. A tick or
// an unused opcode passes S_APPLY and then waits in S_RESULT until the output
// register is free. A setting change reruns the derivation: a restoring divider
// gives the period, and the phase product, a reciprocal multiply by 1/360 and
// the window bounds then follow in turn, each registered, before the result
// goes to the output register. A configuration write and reset start the same
// derivation, which keeps in_tready low until it ends; configuration writes are
// taken at any time. The next item is taken while the previous result still
// waits in the output register.
module two_phase_square_wave_generator_top
  import tpsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // opcode[2:0], new_setting[9:3]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,  // wave_a[0], wave_b[1], setting_value[8:2],
                                         // period_ticks[24:9]
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tpsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_we    (cfg_we),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpsw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> bench/two_phase_wave_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_wave_checker
// Watches the item, result and register ports of the square wave generator,
// keeps its own copy of the setting, counter, period and phase, predicts the
// wave levels of every accepted item and compares each result field by field.
// ----------------------------------------------------------------------------
module two_phase_wave_checker
  import tpsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [15:0]        in_tdata,   // opcode[2:0], new_setting[9:3]
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [31:0]        out_tdata,  // wave_a[0], wave_b[1], setting_value[8:2],
                                         // period_ticks[24:9]
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  output int                 mismatches,
  output int                 outstanding
);

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic             wave_a;
    logic             wave_b;
    logic [SET_W-1:0] setting;
    logic [PER_W-1:0] period;
  } wave_sample_t;

  wave_sample_t waves_due[$];

  logic [6:0]       base_hz;
  logic [15:0]      tps;
  logic [5:0]       step_deg;
  logic [SET_W-1:0] setting;
  int unsigned      count;
  logic [PER_W-1:0] period;
  logic [PH_W-1:0]  phase;
  int               reports;

  function automatic logic in_window(input int unsigned c, input int unsigned p,
                                     input int unsigned ph);
    int unsigned prod;
    prod = p * ph;
    return (c >= (prod + DEG_FULL - 1) / DEG_FULL) && (c <= p / 2 + prod / DEG_FULL);
  endfunction

  function automatic void rederive();
    int unsigned freq;
    int unsigned ph;
    freq = base_hz + setting / TENS_STEP;
    if (freq == 0) begin
      freq = 1;
    end
    period = PER_W'(tps / freq);
    ph = step_deg * (setting % TENS_STEP);
    phase = (ph > PHASE_SAT) ? PHASE_SAT : PH_W'(ph);
  endfunction

  function automatic void restart_model();
    base_hz  = BASE_HZ_RST;
    tps      = TPS_RST;
    step_deg = PHASE_STEP_RST;
    setting  = SETTING_RST;
    count    = 0;
    rederive();
  endfunction

  function automatic wave_sample_t step_generator(input logic [2:0] op,
                                                  input logic [SET_W-1:0] ns);
    wave_sample_t s;
    case (op)
      OP_TICK: begin
        count = count + 1;
        if (count > period) begin
          count = 0;
        end
      end
      OP_TENS_UP: begin
        if (setting <= SETTING_MAX - TENS_STEP) setting = setting + TENS_STEP;
      end
      OP_TENS_DN: begin
        if (setting >= TENS_STEP) setting = setting - TENS_STEP;
      end
      OP_UNITS_UP: begin
        if (setting < SETTING_MAX) setting = setting + 1'b1;
      end
      OP_UNITS_DN: begin
        if (setting > 0) setting = setting - 1'b1;
      end
      OP_LOAD: begin
        setting = (ns > SETTING_MAX) ? SETTING_MAX : ns;
      end
      default: ;
    endcase
    if (op != OP_TICK && op <= OP_LOAD) begin
      rederive();
    end
    s.wave_a = (count <= period / 2);
    if (phase <= DEG_HALF) begin
      s.wave_b = in_window(count, period, phase);
    end else begin
      s.wave_b = !in_window(count, period, phase - DEG_HALF);
    end
    s.setting = setting;
    s.period  = period;
    return s;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      reports++;
      if (reports <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    wave_sample_t want;
    if (!rst_n) begin
      restart_model();
      waves_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_BASE_HZ:    base_hz  = cfg_wdata[6:0];
          REG_TPS:        tps      = cfg_wdata[15:0];
          REG_PHASE_STEP: step_deg = cfg_wdata[5:0];
          default: ;
        endcase
        if (cfg_addr <= REG_PHASE_STEP) begin
          rederive();
        end
      end
      if (in_tvalid && in_tready) begin
        waves_due.push_back(step_generator(in_tdata[2:0], in_tdata[9:3]));
      end
      if (out_tvalid && out_tready) begin
        if (waves_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with none expected, expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = waves_due.pop_front();
          check_field("wave_a", want.wave_a, out_tdata[0]);
          check_field("wave_b", want.wave_b, out_tdata[1]);
          check_field("setting_value", want.setting, out_tdata[8:2]);
          check_field("period_ticks", want.period, out_tdata[24:9]);
        end
      end
    end
    outstanding = waves_due.size();
  end

endmodule

>>> bench/tb_two_phase_square_wave_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_phase_square_wave_generator_top
// Drives setting, tick and unused opcode items into the square wave generator
// with random gaps and result stalls, reprograms its registers between phases
// (extremes, zero frequency, phase saturation, the longest period) and reports
// the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_two_phase_square_wave_generator_top;
  import tpsw_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam logic [2:0]  OP_SPARE_LO = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [15:0]        in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_D_W-1:0] cfg_wdata;
  int                 mismatches;
  int                 outstanding;

  logic rushed;
  logic in_quiet;
  logic out_quiet;
  int   items_sent;
  int   reg_writes;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  two_phase_square_wave_generator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  two_phase_wave_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic int draw_wait(input logic quiet);
    return quiet ? 0 : int'($urandom_range(0, 15));
  endfunction

  task automatic push_item(input logic [2:0] op, input logic [6:0] ns);
    int gap;
    if ($urandom_range(0, 47) == 0) in_quiet = ~in_quiet;
    gap = draw_wait(rushed || in_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      in_tdata  = 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {6'b0, ns, op};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // registers change only once every result is back
  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] data);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
  endtask

  task automatic run_phase(input logic [6:0] base, input logic [15:0] tps,
                           input logic [5:0] step, input int n);
    int r;
    logic [2:0] op;
    write_reg(REG_BASE_HZ, CFG_D_W'(base));
    write_reg(REG_TPS, tps);
    write_reg(REG_PHASE_STEP, CFG_D_W'(step));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 60) op = OP_TICK;
      else if (r < 94) op = 3'($urandom_range(OP_TENS_UP, OP_LOAD));
      else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      push_item(op, 7'($urandom_range(0, 127)));
    end
  endtask

  // result side
  initial begin
    int stall;
    out_tready = 1'b0;
    out_quiet  = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 47) == 0) out_quiet = ~out_quiet;
      stall = draw_wait(rushed || out_quiet);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    rushed     = 1'b0;
    in_quiet   = 1'b0;
    items_sent = 0;
    reg_writes = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // setting limits, out of range loads, unused opcodes
    push_item(OP_TICK, 7'd0);
    push_item(OP_TICK, 7'd0);
    push_item(OP_TICK, 7'h7f);
    push_item(OP_SPARE_LO, 7'd5);
    push_item(OP_SPARE_HI, 7'h7f);
    push_item(OP_LOAD, 7'd0);
    push_item(OP_UNITS_DN, 7'd0);
    push_item(OP_TENS_DN, 7'd0);
    push_item(OP_LOAD, 7'd127);
    push_item(OP_UNITS_UP, 7'd0);
    push_item(OP_TENS_UP, 7'd0);
    push_item(OP_LOAD, 7'd100);
    push_item(OP_LOAD, 7'd89);
    push_item(OP_TENS_UP, 7'd0);
    push_item(OP_LOAD, 7'd10);
    push_item(OP_TENS_DN, 7'd0);
    push_item(OP_LOAD, 7'd9);
    push_item(OP_UNITS_UP, 7'd0);
    push_item(OP_UNITS_DN, 7'd0);
    push_item(OP_LOAD, 7'd7);
    push_item(OP_TICK, 7'd0);
    // zero frequency and phase saturation
    write_reg(REG_PHASE_STEP, CFG_D_W'(63));
    write_reg(REG_BASE_HZ, CFG_D_W'(0));
    push_item(OP_TICK, 7'd0);
    push_item(OP_LOAD, 7'd9);
    push_item(OP_TICK, 7'd0);

    // longest period, back to back ticks
    write_reg(REG_TPS, 16'hffff);
    write_reg(REG_PHASE_STEP, CFG_D_W'(39));
    push_item(OP_LOAD, 7'd0);
    rushed = 1'b1;
    repeat (40) push_item(OP_TICK, 7'($urandom_range(0, 127)));
    rushed = 1'b0;

    run_phase(7'd1, 16'd100, 6'd39, 185);
    run_phase(7'd64, 16'hffff, 6'd0, 185);
    run_phase(7'd127, 16'd300, 6'd63, 185);
    run_phase(7'd0, 16'd200, 6'd13, 185);
    run_phase(7'd20, 16'd1000, 6'd30, 185);
    run_phase(7'd33, 16'd0, 6'd17, 185);
    run_phase(7'($urandom_range(1, 64)), 16'($urandom_range(100, 800)),
              6'($urandom_range(0, 39)), 185);
    run_phase(7'($urandom_range(1, 64)), 16'($urandom_range(100, 800)),
              6'($urandom_range(0, 39)), 185);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("run covered %0d items and %0d register writes", items_sent, reg_writes);
    $display("including setting limits, zero frequency, phase saturation and a counter wrap");
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
